>>> design/tccw_pkg.sv
// Shared constants, codes and types of the text console cell writer.
package tccw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
    localparam int ADDR_W     = 11;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int CELL_W     = 16;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ENABLE = 2'd2;

    localparam logic [3:0] TEXT_COLOR_RESET = 4'hF;
    localparam logic [2:0] BACK_COLOR_RESET = 3'd0;

    // Request modes
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0F20;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_COPY,
        S_FILL,
        S_RESULT
    } seq_state_t;

    typedef struct packed {
        logic              step;
        logic              home;
        logic [CHAR_W-1:0] ch;
    } cur_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_blank;
        logic              scroll;
    } cur_status_t;

endpackage

>>> design/tccw_if.sv
// Request, result and configuration channel interfaces.
interface tccw_req_if;
    import tccw_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;

    modport source (output valid, output mode, output char_code, output cell_address,
                    input ready);
    modport sink   (input valid, input mode, input char_code, input cell_address,
                    output ready);
endinterface

interface tccw_rsp_if;
    import tccw_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] cursor_offset;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;

    modport source (output valid, output cursor_offset, output cell_data, output scrolled,
                    input ready);
    modport sink   (input valid, input cursor_offset, input cell_data, input scrolled,
                    output ready);
endinterface

interface tccw_cfg_if;
    import tccw_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/tccw_cell_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tccw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/tccw_cursor.sv
// Cursor registers and the per-character cursor and cell-write decision.
module tccw_cursor (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tccw_pkg::cur_cmd_t    cmd,
    output tccw_pkg::cur_status_t status
);
    import tccw_pkg::*;

    localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] lin;
    logic              advance;

    assign lin = ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg);

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        advance         = 1'b0;
        status.offset   = lin;
        status.wr_en    = 1'b0;
        status.wr_addr  = lin;
        status.wr_blank = 1'b0;
        status.scroll   = 1'b0;

        if (cmd.ch == CH_CR)
        begin
            col_next = '0;
        end
        else if (cmd.ch == CH_LF)
        begin
            col_next = '0;
            advance  = 1'b1;
        end
        else if (cmd.ch == CH_BS)
        begin
            status.wr_en    = 1'b1;
            status.wr_blank = 1'b1;
            status.wr_addr  = (lin == '0) ? '0 : lin - ADDR_W'(1);
            if (col_reg != '0)
            begin
                col_next = col_reg - COL_W'(1);
            end
            else if (row_reg != '0)
            begin
                row_next = row_reg - ROW_W'(1);
                col_next = COL_LAST;
            end
        end
        else if (cmd.ch >= CH_SPACE)
        begin
            status.wr_en = 1'b1;
            if (col_reg == COL_LAST)
            begin
                col_next = '0;
                advance  = 1'b1;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end

        // stepping past the bottom row keeps the cursor there and scrolls
        if (advance)
        begin
            if (row_reg == ROW_LAST)
            begin
                status.scroll = 1'b1;
            end
            else
            begin
                row_next = row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.home)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.step)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> design/tccw_seq.sv
// Request sequencer: cell memory walks, read-modify-write control and result register.
module tccw_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    tccw_req_if.sink                      req,
    tccw_rsp_if.source                    rsp,
    input  logic [tccw_pkg::ATTR_W-1:0]   char_attr,
    input  logic [tccw_pkg::CELL_W-1:0]   fill_cell,
    output tccw_pkg::cur_cmd_t            cur_cmd,
    input  tccw_pkg::cur_status_t         cur_status,
    output logic                          ram_we,
    output logic [tccw_pkg::ADDR_W-1:0]   ram_waddr,
    output logic [tccw_pkg::CELL_W-1:0]   ram_wdata,
    output logic                          ram_re,
    output logic [tccw_pkg::ADDR_W-1:0]   ram_raddr,
    input  logic [tccw_pkg::CELL_W-1:0]   ram_rdata
);
    import tccw_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(COPY_COUNT);
    localparam logic [ADDR_W-1:0] CELLS_A   = ADDR_W'(CELL_COUNT);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);

    seq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              pending_reg, pending_next;
    logic              out_valid_reg, out_valid_next;
    logic [CELL_W-1:0] data_reg, data_next;
    logic              scr_reg, scr_next;
    logic [ADDR_W-1:0] out_offset_reg;
    logic [CELL_W-1:0] out_data_reg;
    logic              out_scr_reg;
    logic              load_out;
    logic              accept;

    assign req.ready         = (state_reg == S_IDLE);
    assign accept            = req.valid && req.ready;
    assign rsp.valid         = out_valid_reg;
    assign rsp.cursor_offset = out_offset_reg;
    assign rsp.cell_data     = out_data_reg;
    assign rsp.scrolled      = out_scr_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pending_next = pending_reg;
        data_next    = data_reg;
        scr_next     = scr_reg;
        load_out     = 1'b0;
        cur_cmd.step = 1'b0;
        cur_cmd.home = 1'b0;
        cur_cmd.ch   = req.char_code;
        ram_we       = 1'b0;
        ram_waddr    = cnt_reg;
        ram_wdata    = fill_cell;
        ram_re       = 1'b0;
        ram_raddr    = req.cell_address;

        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = RESET_BLANK;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    data_next = '0;
                    scr_next  = 1'b0;
                    cnt_next  = '0;
                    unique case (req.mode)
                        MODE_PUT:
                        begin
                            cur_cmd.step = 1'b1;
                            ram_we       = cur_status.wr_en;
                            ram_waddr    = cur_status.wr_addr;
                            ram_wdata    = cur_status.wr_blank ? fill_cell
                                                               : {char_attr, req.char_code};
                            scr_next     = cur_status.scroll;
                            pending_next = 1'b0;
                            state_next   = cur_status.scroll ? S_COPY : S_RESULT;
                        end
                        MODE_READ:
                        begin
                            if (req.cell_address < CELLS_A)
                            begin
                                ram_re     = 1'b1;
                                state_next = S_READ;
                            end
                            else
                            begin
                                state_next = S_RESULT;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            cur_cmd.home = 1'b1;
                            state_next   = S_FILL;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                data_next  = ram_rdata;
                state_next = S_RESULT;
            end
            S_COPY:
            begin
                // write follows read in the next cycle; destination is one row above the source
                if (pending_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg - ADDR_W'(1);
                    ram_wdata = ram_rdata;
                end
                if (cnt_reg == COPY_END)
                begin
                    pending_next = 1'b0;
                    state_next   = S_FILL;
                end
                else
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = cnt_reg + COLS_A;
                    cnt_next     = cnt_reg + ADDR_W'(1);
                    pending_next = 1'b1;
                end
            end
            S_FILL:
            begin
                ram_we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        scr_reg  <= scr_next;
        if (load_out)
        begin
            out_offset_reg <= cur_status.offset;
            out_data_reg   <= data_reg;
            out_scr_reg    <= scr_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("cell memory read and write hit the same entry");

    a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY) |-> (cnt_reg <= COPY_END))
        else $error("scroll copy ran past the last source row");

    a_copy_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_COPY) |-> ($past(state_reg) == S_IDLE))
        else $error("scroll started outside a put request");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_RESULT))
        else $error("result register loaded outside the result state");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (cur_status.offset < CELLS_A))
        else $error("cursor offset outside the screen");
`endif

endmodule

>>> design/text_console_cell_writer.sv
// Top level of the text console cell writer: configuration registers and block wiring.
//
// A text screen of ROWS x COLUMNS 16-bit cells (attribute high byte, character low
// byte) lives in one synchronous single-port-write cell RAM, with the cursor kept in
// registers. Every request returns one result carrying the cursor offset after the
// request, the cell data (read mode only, else 0) and a scroll flag. Steps per request:
// put character without scroll writes in the accept cycle and then loads the result;
// ignored modes and reads past the screen only load the result; read cell reads the
// RAM (registered read data) and then loads the result; a put that scrolls handles the
// character in the accept cycle, copies the COLUMNS*(ROWS-1) cells below the top row
// up one row through the RAM read port, fills the COLUMNS cells of the bottom row and
// loads the result; clear homes the cursor at accept, writes one blank per cell and
// then loads the result. After reset a clearing pass writes the reset blank into every
// cell, during which no request is accepted; configuration writes are accepted at any
// time (cfg.ready is always high). A new request may be accepted while the previous
// result still waits on rsp; it stalls at its result if the output register is still
// full.
module text_console_cell_writer (
    input logic      clk,
    input logic      rst_n,
    tccw_req_if.sink   req,
    tccw_rsp_if.source rsp,
    tccw_cfg_if.sink   cfg
);
    import tccw_pkg::*;

    logic [3:0] text_color_reg;
    logic [2:0] back_color_reg;
    logic       blink_reg;

    logic [ATTR_W-1:0] char_attr;
    logic [CELL_W-1:0] fill_cell;

    cur_cmd_t    cur_cmd;
    cur_status_t cur_status;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // config port never stalls; indexes beyond the list are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= TEXT_COLOR_RESET;
            back_color_reg <= BACK_COLOR_RESET;
            blink_reg      <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_TEXT_COLOR:   text_color_reg <= cfg.data[3:0];
                CFG_BACK_COLOR:   back_color_reg <= cfg.data[2:0];
                CFG_BLINK_ENABLE: blink_reg      <= cfg.data[0];
                default:          ;
            endcase
        end
    end

    // written characters use the plain attribute; blanks add the blink bit
    assign char_attr = {1'b0, back_color_reg, text_color_reg};
    assign fill_cell = {blink_reg, back_color_reg, text_color_reg, CH_SPACE};

    tccw_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .char_attr  (char_attr),
        .fill_cell  (fill_cell),
        .cur_cmd    (cur_cmd),
        .cur_status (cur_status),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    tccw_cursor u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cur_cmd),
        .status (cur_status)
    );

    tccw_cell_ram #(
        .DEPTH (CELL_COUNT),
        .WIDTH (CELL_W),
        .AW    (ADDR_W)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
